// ----- hw/rtl/rln_pkg.sv -----
// Shared types and constants for the RGB light normalizer.
// Word structs, register map and fixed arithmetic widths; no dependencies.
package rln_pkg;

    typedef struct packed {
        logic [15:0] clear_count;
        logic [15:0] red_count;
        logic [15:0] green_count;
        logic [15:0] blue_count;
    } sample_t;

    typedef struct packed {
        logic [15:0] intensity;
        logic [23:0] irradiance;
        logic        irradiance_saturated;
        logic [16:0] red_share;
        logic [16:0] green_share;
        logic [16:0] blue_share;
        logic [15:0] wavelength;
    } result_t;

    localparam logic [2:0] REG_DARK_OFFSET = 3'd0;
    localparam logic [2:0] REG_RESP_BASE   = 3'd1;
    localparam logic [2:0] REG_ANALOG_GAIN = 3'd2;
    localparam logic [2:0] REG_DIGITAL_GAIN = 3'd3;
    localparam logic [2:0] REG_HIGH_SENS   = 3'd4;
    localparam logic [2:0] REG_INT_CODE    = 3'd5;
    localparam logic [2:0] REG_REF_CODE    = 3'd6;

    localparam logic [1:0] GAIN_X1   = 2'd0;
    localparam logic [1:0] GAIN_X2   = 2'd1;
    localparam logic [1:0] GAIN_X4   = 2'd2;
    localparam logic [1:0] GAIN_HALF = 2'd3;

    localparam logic [23:0] RESP_BASE_RESET = 24'd65536;
    localparam logic [23:0] IRR_MAX         = 24'hFFFFFF;
    localparam logic [9:0]  WL_RED          = 10'd620;
    localparam logic [9:0]  WL_GREEN        = 10'd550;
    localparam logic [9:0]  WL_BLUE         = 10'd470;

    localparam int DIV_STAGES = 24;
    localparam int FRONT_STAGES = 3;

endpackage

// ----- hw/rtl/rln_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Requires dividend >> QW below divisor; no package dependencies.
module rln_div #(
    parameter int NW = 46,
    parameter int DW = 31,
    parameter int QW = 24
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quotient
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [DW-1:0] div_reg [QW];

    logic [DW-1:0] rem_in  [QW];
    logic [QW-1:0] lo_in   [QW];
    logic [QW-1:0] q_in    [QW];
    logic [DW-1:0] div_in  [QW];
    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] q_next  [QW];

    always_comb
    begin
        rem_in[0] = DW'(dividend >> QW);
        lo_in[0]  = dividend[QW-1:0];
        q_in[0]   = '0;
        div_in[0] = divisor;
        for (int k = 1; k < QW; k++)
        begin
            rem_in[k] = rem_reg[k-1];
            lo_in[k]  = lo_reg[k-1];
            q_in[k]   = q_reg[k-1];
            div_in[k] = div_reg[k-1];
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;
        assign trial = {rem_in[k], lo_in[k][QW-1]};
        assign diff  = trial - {1'b0, div_in[k]};
        assign ge    = trial >= {1'b0, div_in[k]};
        assign rem_next[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign q_next[k]   = {q_in[k][QW-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k]  <= lo_in[k] << 1;
                q_reg[k]   <= q_next[k];
                div_reg[k] <= div_in[k];
            end
        end
    end

    assign quotient = q_reg[QW-1];

endmodule

// ----- hw/rtl/rgb_light_normalizer.sv -----
// RGB light normalizer: three front stages, then 24 divider stages (one quotient
// bit each); throughput one word per cycle while the output is not stalled.
// A stalled output holds the whole pipeline; the input stalls in the same cycle.
// Reset clears all valid bits and loads register defaults (base 1.0, others 0).
// Depends on rln_pkg and rln_div.
module rgb_light_normalizer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  rln_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_stall,
    output rln_pkg::result_t result
);
    import rln_pkg::*;

    localparam int DEPTH = FRONT_STAGES + DIV_STAGES;

    logic [15:0] dark_reg;
    logic [23:0] base_reg;
    logic [1:0]  again_reg;
    logic [1:0]  dgain_reg;
    logic        hsens_reg;
    logic [1:0]  itime_reg;
    logic [1:0]  rtime_reg;

    logic [2:0]  cfg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_reg  <= '0;
            base_reg  <= RESP_BASE_RESET;
            again_reg <= GAIN_X1;
            dgain_reg <= GAIN_X1;
            hsens_reg <= 1'b0;
            itime_reg <= '0;
            rtime_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_DARK_OFFSET:  dark_reg  <= pwdata[15:0];
                REG_RESP_BASE:    base_reg  <= pwdata[23:0];
                REG_ANALOG_GAIN:  again_reg <= pwdata[1:0];
                REG_DIGITAL_GAIN: dgain_reg <= pwdata[1:0];
                REG_HIGH_SENS:    hsens_reg <= pwdata[0];
                REG_INT_CODE:     itime_reg <= pwdata[1:0];
                REG_REF_CODE:     rtime_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_DARK_OFFSET:  prdata = {16'd0, dark_reg};
            REG_RESP_BASE:    prdata = {8'd0, base_reg};
            REG_ANALOG_GAIN:  prdata = {30'd0, again_reg};
            REG_DIGITAL_GAIN: prdata = {30'd0, dgain_reg};
            REG_HIGH_SENS:    prdata = {31'd0, hsens_reg};
            REG_INT_CODE:     prdata = {30'd0, itime_reg};
            REG_REF_CODE:     prdata = {30'd0, rtime_reg};
            default:          prdata = '0;
        endcase
    end

    // responsivity factors: numerator multiplier and denominator shift
    logic [2:0] mbase;
    logic [1:0] nshift;
    logic [5:0] mult;
    logic [1:0] ashift;
    logic [1:0] dshift_g;
    logic [2:0] dshift;
    logic [30:0] den;

    always_comb
    begin
        mbase = 3'd1;
        if (again_reg == GAIN_HALF)
        begin
            mbase = 3'd2;
        end
        if (hsens_reg)
        begin
            mbase = 3'(mbase * 3'd3);
        end
        nshift = (rtime_reg > itime_reg) ? 2'(rtime_reg - itime_reg) : 2'd0;
        mult   = 6'(mbase) << nshift;
        case (again_reg)
            GAIN_X2: ashift = 2'd1;
            GAIN_X4: ashift = 2'd2;
            default: ashift = 2'd0;
        endcase
        case (dgain_reg)
            GAIN_X2: dshift_g = 2'd1;
            GAIN_X4: dshift_g = 2'd2;
            default: dshift_g = 2'd0;
        endcase
        dshift = 3'(ashift) + 3'(dshift_g)
               + ((itime_reg > rtime_reg) ? 3'(itime_reg - rtime_reg) : 3'd0);
        den = 31'(base_reg) << dshift;
    end

    logic en;
    logic v_reg [DEPTH];

    assign result_valid = v_reg[DEPTH-1];
    assign en           = !(result_valid && result_stall);
    assign sample_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= sample_valid;
            for (int k = 1; k < DEPTH; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // stage 1: dark subtraction
    logic [15:0] s1_c_reg, s1_r_reg, s1_g_reg, s1_b_reg;
    // stage 2: products and sums
    logic [21:0] s2_im_reg;
    logic [30:0] s2_den_reg;
    logic        s2_bz_reg;
    logic [15:0] s2_c_reg, s2_r_reg, s2_g_reg, s2_b_reg;
    logic [17:0] s2_sum_reg;
    logic [26:0] s2_wn_reg;
    // stage 3: saturation check
    logic [21:0] s3_im_reg;
    logic [30:0] s3_den_reg;
    logic        s3_sat_reg;
    logic        s3_bz_reg;
    logic [15:0] s3_c_reg, s3_r_reg, s3_g_reg, s3_b_reg;
    logic [17:0] s3_sum_reg;
    logic [26:0] s3_wn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_c_reg <= (sample.clear_count > dark_reg) ? sample.clear_count - dark_reg : '0;
            s1_r_reg <= (sample.red_count > dark_reg) ? sample.red_count - dark_reg : '0;
            s1_g_reg <= (sample.green_count > dark_reg) ? sample.green_count - dark_reg : '0;
            s1_b_reg <= (sample.blue_count > dark_reg) ? sample.blue_count - dark_reg : '0;

            s2_im_reg  <= 22'(s1_c_reg) * 22'(mult);
            s2_den_reg <= den;
            s2_bz_reg  <= (base_reg == '0);
            s2_c_reg   <= s1_c_reg;
            s2_r_reg   <= s1_r_reg;
            s2_g_reg   <= s1_g_reg;
            s2_b_reg   <= s1_b_reg;
            s2_sum_reg <= 18'(s1_r_reg) + 18'(s1_g_reg) + 18'(s1_b_reg);
            s2_wn_reg  <= 27'(s1_r_reg) * 27'(WL_RED) + 27'(s1_g_reg) * 27'(WL_GREEN)
                        + 27'(s1_b_reg) * 27'(WL_BLUE);

            s3_im_reg  <= s2_im_reg;
            s3_den_reg <= s2_den_reg;
            s3_sat_reg <= 31'(s2_im_reg) >= s2_den_reg;
            s3_bz_reg  <= s2_bz_reg;
            s3_c_reg   <= s2_c_reg;
            s3_r_reg   <= s2_r_reg;
            s3_g_reg   <= s2_g_reg;
            s3_b_reg   <= s2_b_reg;
            s3_sum_reg <= s2_sum_reg;
            s3_wn_reg  <= s2_wn_reg;
        end
    end

    // sideband carried alongside the dividers
    logic [15:0] sb_c_reg   [DIV_STAGES];
    logic        sb_sat_reg [DIV_STAGES];
    logic        sb_bz_reg  [DIV_STAGES];
    logic        sb_sz_reg  [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_c_reg[0]   <= s3_c_reg;
            sb_sat_reg[0] <= s3_sat_reg;
            sb_bz_reg[0]  <= s3_bz_reg;
            sb_sz_reg[0]  <= (s3_sum_reg == '0);
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                sb_c_reg[k]   <= sb_c_reg[k-1];
                sb_sat_reg[k] <= sb_sat_reg[k-1];
                sb_bz_reg[k]  <= sb_bz_reg[k-1];
                sb_sz_reg[k]  <= sb_sz_reg[k-1];
            end
        end
    end

    logic [DIV_STAGES-1:0] q_irr, q_r, q_g, q_b, q_wl;

    rln_div #(.NW(46), .DW(31), .QW(DIV_STAGES)) u_div_irr (
        .clk(clk), .en(en), .dividend({s3_im_reg, 24'd0}),
        .divisor(s3_den_reg), .quotient(q_irr));
    rln_div #(.NW(32), .DW(18), .QW(DIV_STAGES)) u_div_r (
        .clk(clk), .en(en), .dividend({s3_r_reg, 16'd0}),
        .divisor(s3_sum_reg), .quotient(q_r));
    rln_div #(.NW(32), .DW(18), .QW(DIV_STAGES)) u_div_g (
        .clk(clk), .en(en), .dividend({s3_g_reg, 16'd0}),
        .divisor(s3_sum_reg), .quotient(q_g));
    rln_div #(.NW(32), .DW(18), .QW(DIV_STAGES)) u_div_b (
        .clk(clk), .en(en), .dividend({s3_b_reg, 16'd0}),
        .divisor(s3_sum_reg), .quotient(q_b));
    rln_div #(.NW(33), .DW(18), .QW(DIV_STAGES)) u_div_wl (
        .clk(clk), .en(en), .dividend({s3_wn_reg, 6'd0}),
        .divisor(s3_sum_reg), .quotient(q_wl));

    logic last_bz, last_sat, last_sz;
    assign last_bz  = sb_bz_reg[DIV_STAGES-1];
    assign last_sat = sb_sat_reg[DIV_STAGES-1];
    assign last_sz  = sb_sz_reg[DIV_STAGES-1];

    always_comb
    begin
        result.intensity            = sb_c_reg[DIV_STAGES-1];
        result.irradiance           = last_bz ? '0 : (last_sat ? IRR_MAX : q_irr[23:0]);
        result.irradiance_saturated = last_sat && !last_bz;
        result.red_share            = last_sz ? '0 : q_r[16:0];
        result.green_share          = last_sz ? '0 : q_g[16:0];
        result.blue_share           = last_sz ? '0 : q_b[16:0];
        result.wavelength           = last_sz ? '0 : q_wl[15:0];
    end

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall))
        else $error("input stalled without a stalled output word");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.irradiance_saturated) |-> (result.irradiance == IRR_MAX))
        else $error("saturated irradiance not at full scale");

    a_share_sum: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (19'(result.red_share) + 19'(result.green_share)
                          + 19'(result.blue_share) <= 19'd65536))
        else $error("color shares exceed one");

    a_wl_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.wavelength <= 16'd39680))
        else $error("wavelength out of range");

endmodule
